/* hw/rtl/idalloc_pkg.sv */
// Shared types, field widths and codes of the id allocator.
package idalloc_pkg;

  localparam int unsigned DEF_MAX_IDS   = 1024;
  localparam int unsigned DEF_MAX_BATCH = 64;

  // fixed field widths of the channels
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned CNT_IN_W = 7;
  localparam int unsigned ID_IN_W  = 10;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCNT_W = 11;

  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RSVD  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STAT_W-1:0] ST_INACTIVE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CHK  = 5'b00010,
    S_EMIT = 5'b00100,
    S_ARD  = 5'b01000,
    S_AGR  = 5'b10000
  } state_t;

endpackage

/* hw/rtl/idalloc_if.sv */
// Valid/ready channel interfaces for requests and results.
interface idalloc_req_if import idalloc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [CNT_IN_W-1:0] count;
  logic [ID_IN_W-1:0]  id;

  modport source (output valid, req_type, count, id, input ready);
  modport sink   (input valid, req_type, count, id, output ready);
endinterface

interface idalloc_res_if import idalloc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [ID_IN_W-1:0] granted_id;
  logic               is_active;
  logic [OCNT_W-1:0]  active_count;
  logic [OCNT_W-1:0]  issued_count;
  logic               last;

  modport source (output valid, status, granted_id, is_active, active_count, issued_count,
                  last, input ready);
  modport sink   (input valid, status, granted_id, is_active, active_count, issued_count,
                  last, output ready);
endinterface

/* hw/rtl/id_allocator_free_stack_unit.sv */
// Top level of the id allocator: sequencer plus active-map and free-stack memories.
//
// Request channel in_ch carries req_type, count and id; result channel out_ch carries
// status, granted_id, is_active, active_count, issued_count and last. Both are
// valid/ready; a transfer happens when valid and ready are high at a clock edge.
// Items are handled one at a time: in_ch.ready is high only while the sequencer idles.
// Free and query: the active-map read is issued at the request transfer and the result
// is loaded in S_CHK once the result register is free; only then is a new item taken.
// Allocate of n ids: per grant, S_ARD issues the registered free-stack read (or uses
// the high-water mark if the stack is empty) and S_AGR loads the result, last set on
// the final one. A rejected allocate (bad count or full), an unused request type and a
// free or query of an id at or above the high-water mark load one result from S_EMIT.
// Reset clears the state, the counters and the result valid flag only; the memories are
// not swept, since only entries below the high-water mark or the free depth are read.
// When out_ch stalls, the result register holds and the sequencer waits in place.
module id_allocator_free_stack_unit import idalloc_pkg::*; #(
  parameter int unsigned MAX_IDS   = DEF_MAX_IDS,
  parameter int unsigned MAX_BATCH = DEF_MAX_BATCH
) (
  input  logic          clk,
  input  logic          rst_n,
  idalloc_req_if.sink   in_ch,
  idalloc_res_if.source out_ch
);

  localparam int unsigned ID_W = $clog2(MAX_IDS);

  logic            am_we, am_wdata, am_re, am_rdata;
  logic [ID_W-1:0] am_waddr, am_raddr;
  logic            fs_we, fs_re;
  logic [ID_W-1:0] fs_waddr, fs_wdata, fs_raddr, fs_rdata;

  idalloc_ctrl #(
    .MAX_IDS  (MAX_IDS),
    .MAX_BATCH(MAX_BATCH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .am_we   (am_we),
    .am_waddr(am_waddr),
    .am_wdata(am_wdata),
    .am_re   (am_re),
    .am_raddr(am_raddr),
    .am_rdata(am_rdata),
    .fs_we   (fs_we),
    .fs_waddr(fs_waddr),
    .fs_wdata(fs_wdata),
    .fs_re   (fs_re),
    .fs_raddr(fs_raddr),
    .fs_rdata(fs_rdata)
  );

  idalloc_ram #(
    .WIDTH(1),
    .DEPTH(MAX_IDS)
  ) u_active_map (
    .clk  (clk),
    .we   (am_we),
    .waddr(am_waddr),
    .wdata(am_wdata),
    .re   (am_re),
    .raddr(am_raddr),
    .rdata(am_rdata)
  );

  idalloc_ram #(
    .WIDTH(ID_W),
    .DEPTH(MAX_IDS)
  ) u_free_stack (
    .clk  (clk),
    .we   (fs_we),
    .waddr(fs_waddr),
    .wdata(fs_wdata),
    .re   (fs_re),
    .raddr(fs_raddr),
    .rdata(fs_rdata)
  );

endmodule

/* hw/rtl/idalloc_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
module idalloc_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/idalloc_ctrl.sv */
// Request sequencer: decodes items, drives both memories and the result register.
module idalloc_ctrl import idalloc_pkg::*; #(
  parameter int unsigned MAX_IDS   = DEF_MAX_IDS,
  parameter int unsigned MAX_BATCH = DEF_MAX_BATCH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  idalloc_req_if.sink                in_ch,
  idalloc_res_if.source              out_ch,
  // active map
  output logic                       am_we,
  output logic [$clog2(MAX_IDS)-1:0] am_waddr,
  output logic                       am_wdata,
  output logic                       am_re,
  output logic [$clog2(MAX_IDS)-1:0] am_raddr,
  input  logic                       am_rdata,
  // free stack
  output logic                       fs_we,
  output logic [$clog2(MAX_IDS)-1:0] fs_waddr,
  output logic [$clog2(MAX_IDS)-1:0] fs_wdata,
  output logic                       fs_re,
  output logic [$clog2(MAX_IDS)-1:0] fs_raddr,
  input  logic [$clog2(MAX_IDS)-1:0] fs_rdata
);

  localparam int unsigned ID_W  = $clog2(MAX_IDS);
  localparam int unsigned CW    = $clog2(MAX_IDS + 1);
  localparam int unsigned CMP_W = (CW > ID_IN_W) ? CW : ID_IN_W;
  localparam logic [CW-1:0]       MAX_IDS_C   = CW'(MAX_IDS);
  localparam logic [CNT_IN_W-1:0] MAX_BATCH_C = CNT_IN_W'(MAX_BATCH);

  state_t              state_r, state_nxt;
  logic [REQ_W-1:0]    req_r, req_nxt;
  logic [CNT_IN_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_IN_W-1:0] k_r, k_nxt;
  logic [ID_IN_W-1:0]  id_r, id_nxt;
  logic [STAT_W-1:0]   em_stat_r, em_stat_nxt;
  logic                pop_r, pop_nxt;
  logic [CW-1:0]       depth_r, depth_nxt;
  logic [CW-1:0]       hw_r, hw_nxt;
  logic [CW-1:0]       live_r, live_nxt;

  logic                ov_r, ov_nxt;
  logic [STAT_W-1:0]   o_stat_r, o_stat_nxt;
  logic [ID_IN_W-1:0]  o_gid_r, o_gid_nxt;
  logic                o_act_r, o_act_nxt;
  logic [OCNT_W-1:0]   o_live_r, o_live_nxt;
  logic [OCNT_W-1:0]   o_hw_r, o_hw_nxt;
  logic                o_last_r, o_last_nxt;

  logic                slot_free;
  logic                load;
  logic                in_xfer;
  logic [CW:0]         avail;
  logic                id_oor;
  logic [ID_W-1:0]     gnt;
  logic                last_gnt;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign slot_free   = !ov_r || out_ch.ready;

  // ids left in the free stack plus the unissued space
  assign avail    = {1'b0, depth_r} + {1'b0, MAX_IDS_C - hw_r};
  assign id_oor   = CMP_W'(in_ch.id) >= CMP_W'(hw_r);
  assign gnt      = pop_r ? fs_rdata : ID_W'(hw_r);
  assign last_gnt = (k_r + CNT_IN_W'(1)) == cnt_r;

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    cnt_nxt     = cnt_r;
    k_nxt       = k_r;
    id_nxt      = id_r;
    em_stat_nxt = em_stat_r;
    pop_nxt     = pop_r;
    depth_nxt   = depth_r;
    hw_nxt      = hw_r;
    live_nxt    = live_r;
    load        = 1'b0;
    o_stat_nxt  = o_stat_r;
    o_gid_nxt   = o_gid_r;
    o_act_nxt   = o_act_r;
    o_live_nxt  = o_live_r;
    o_hw_nxt    = o_hw_r;
    o_last_nxt  = o_last_r;
    am_we       = 1'b0;
    am_waddr    = ID_W'(id_r);
    am_wdata    = 1'b0;
    am_re       = 1'b0;
    am_raddr    = ID_W'(in_ch.id);
    fs_we       = 1'b0;
    fs_waddr    = ID_W'(depth_r);
    fs_wdata    = ID_W'(id_r);
    fs_re       = 1'b0;
    fs_raddr    = ID_W'(depth_r - CW'(1));

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          req_nxt = in_ch.req_type;
          cnt_nxt = in_ch.count;
          id_nxt  = in_ch.id;
          k_nxt   = '0;
          if (in_ch.req_type == REQ_ALLOC) begin
            id_nxt = '0;
            if (in_ch.count == '0 || in_ch.count > MAX_BATCH_C) begin
              em_stat_nxt = ST_RANGE;
              state_nxt   = S_EMIT;
            end else if (avail < (CW+1)'(in_ch.count)) begin
              em_stat_nxt = ST_FULL;
              state_nxt   = S_EMIT;
            end else begin
              state_nxt = S_ARD;
            end
          end else if (in_ch.req_type == REQ_RSVD || id_oor) begin
            em_stat_nxt = ST_RANGE;
            state_nxt   = S_EMIT;
          end else begin
            // every id below the high-water mark was written when issued
            am_re     = 1'b1;
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (slot_free) begin
          load       = 1'b1;
          o_gid_nxt  = id_r;
          o_last_nxt = 1'b1;
          if (!am_rdata) begin
            o_stat_nxt = ST_INACTIVE;
            o_act_nxt  = 1'b0;
          end else if (req_r == REQ_FREE) begin
            am_we    = 1'b1;
            am_wdata = 1'b0;
            if (depth_r != MAX_IDS_C) begin
              fs_we     = 1'b1;
              depth_nxt = depth_r + CW'(1);
            end
            if (live_r != '0) begin
              live_nxt = live_r - CW'(1);
            end
            o_stat_nxt = ST_OK;
            o_act_nxt  = 1'b0;
          end else begin
            o_stat_nxt = ST_OK;
            o_act_nxt  = 1'b1;
          end
          o_live_nxt = OCNT_W'(live_nxt);
          o_hw_nxt   = OCNT_W'(hw_r);
          state_nxt  = S_IDLE;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          load       = 1'b1;
          o_stat_nxt = em_stat_r;
          o_gid_nxt  = id_r;
          o_act_nxt  = 1'b0;
          o_live_nxt = OCNT_W'(live_r);
          o_hw_nxt   = OCNT_W'(hw_r);
          o_last_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_ARD: begin
        // reuse the most recently freed id first
        pop_nxt   = (depth_r != '0);
        fs_re     = (depth_r != '0);
        state_nxt = S_AGR;
      end
      S_AGR: begin
        if (slot_free) begin
          load     = 1'b1;
          am_we    = 1'b1;
          am_waddr = gnt;
          am_wdata = 1'b1;
          live_nxt = live_r + CW'(1);
          if (pop_r) begin
            depth_nxt = depth_r - CW'(1);
          end else begin
            hw_nxt = hw_r + CW'(1);
          end
          o_stat_nxt = ST_OK;
          o_gid_nxt  = ID_IN_W'(gnt);
          o_act_nxt  = 1'b1;
          o_live_nxt = OCNT_W'(live_nxt);
          o_hw_nxt   = OCNT_W'(hw_nxt);
          o_last_nxt = last_gnt;
          k_nxt      = k_r + CNT_IN_W'(1);
          state_nxt  = last_gnt ? S_IDLE : S_ARD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load) begin
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      depth_r <= '0;
      hw_r    <= '0;
      live_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
      hw_r    <= hw_nxt;
      live_r  <= live_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    cnt_r     <= cnt_nxt;
    k_r       <= k_nxt;
    id_r      <= id_nxt;
    em_stat_r <= em_stat_nxt;
    pop_r     <= pop_nxt;
    o_stat_r  <= o_stat_nxt;
    o_gid_r   <= o_gid_nxt;
    o_act_r   <= o_act_nxt;
    o_live_r  <= o_live_nxt;
    o_hw_r    <= o_hw_nxt;
    o_last_r  <= o_last_nxt;
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.status       = o_stat_r;
  assign out_ch.granted_id   = o_gid_r;
  assign out_ch.is_active    = o_act_r;
  assign out_ch.active_count = o_live_r;
  assign out_ch.issued_count = o_hw_r;
  assign out_ch.last         = o_last_r;

  // every issued id is either live or parked on the free stack
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, depth_r} + {1'b0, live_r}) == {1'b0, hw_r})
    else $error("free depth plus live count differs from high-water mark");

  a_hw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r <= MAX_IDS_C)
    else $error("high-water mark above id space");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (load && o_last_nxt) |=> (state_r == S_IDLE))
    else $error("final result loaded but sequencer not back to idle");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AGR && pop_r) |-> (depth_r != '0))
    else $error("pop from an empty free stack");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |-> !load)
    else $error("result register overwritten while stalled");

endmodule
